@@ rtl/core/pcws_pkg.sv @@
// Package: shared types and constants for the pulse channel with sweep.
`default_nettype none
package pcws_pkg;
	localparam int unsigned PERIOD_BASE = 2048;
	localparam int unsigned TIMER_SCALE = 4;
	localparam int unsigned LENGTH_FULL = 64;
	localparam int unsigned CNT_W = 18;
	localparam int unsigned DIV_W = 16;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_FRAME   = 2'd1;
	localparam logic [1:0] OP_TRIGGER = 2'd2;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	localparam logic [2:0] CFG_SWEEP    = 3'd0;
	localparam logic [2:0] CFG_ENVELOPE = 3'd1;
	localparam logic [2:0] CFG_DUTY     = 3'd2;
	localparam logic [2:0] CFG_PERIOD   = 3'd3;
	localparam logic [2:0] CFG_LENGTH   = 3'd4;
	localparam logic [2:0] CFG_PATTERNS = 3'd5;

	localparam logic [31:0] PATTERNS_RESET = 32'h7EE1_8180;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
		logic       evaluate;
		logic       div_step;
		logic       finish;
	} pcws_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} pcws_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/pcws_ctrl.sv @@
// Controller: sequences one item through evaluate, divide and result phases.
`default_nettype none
module pcws_ctrl
	import pcws_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire logic [1:0] in_op,
	input  wire pcws_sts_t sts,
	input  wire logic      out_free,
	output logic           busy,
	output pcws_cmd_t      cmd
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_EVAL;
				ST_EVAL: state_q <= sts.need_div ? ST_DIV : ST_DONE;
				ST_DIV:  if (sts.div_last) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.start    = in_fire;
		cmd.op       = in_op;
		cmd.evaluate = (state_q == ST_EVAL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_DONE) && out_free;
		busy         = (state_q != ST_IDLE);
	end
endmodule
`default_nettype wire

@@ rtl/core/pcws_dp.sv @@
// Datapath: channel state, reload divider, sweep, envelope and length logic.
`default_nettype none
module pcws_dp
	import pcws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pcws_cmd_t   cmd,
	input  wire logic [15:0] in_cycles,
	input  wire logic [2:0]  in_step,
	input  wire logic [6:0]  sweep_ctl,
	input  wire logic [7:0]  env_ctl,
	input  wire logic [1:0]  duty_sel,
	input  wire logic [10:0] period_set,
	input  wire logic        len_en,
	input  wire logic [31:0] patterns,
	output pcws_sts_t        sts,
	output logic [3:0]       sample,
	output logic             chan_on,
	output logic [10:0]      cur_period
);
	logic               enabled_q, sweep_on_q;
	logic [10:0]        period_q, shadow_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic [1:0]         dtype_q;
	logic [2:0]         dpos_q, env_cnt_q;
	logic [3:0]         vol_q, sw_cnt_q, sample_q;
	logic [6:0]         len_q;
	logic [1:0]         op_q;
	logic [15:0]        cycles_q;
	logic [2:0]         step_q;
	logic               need_div_q;
	// divider
	logic [DIV_W-1:0]   dvd_q, quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [4:0]         dcnt_q;

	logic conv_on;
	assign conv_on = |env_ctl[7:3];

	logic [CNT_W-1:0] reload_set;
	assign reload_set = CNT_W'(PERIOD_BASE - 32'(period_set)) * CNT_W'(TIMER_SCALE);

	logic signed [CNT_W-1:0] cnt_sub;
	assign cnt_sub = cnt_q - $signed({2'b00, cycles_q});

	logic need_div_now;
	assign need_div_now = (op_q == OP_TICK) && enabled_q && conv_on && (cnt_sub <= 0);

	// sweep arithmetic on shadow, and for a trigger on the set period
	logic [11:0] sw_off, sw_next;
	assign sw_off  = {1'b0, shadow_q >> sweep_ctl[2:0]};
	assign sw_next = sweep_ctl[3] ? ({1'b0, shadow_q} - sw_off) : ({1'b0, shadow_q} + sw_off);

	logic [11:0] sw_off2, sw_next2;
	assign sw_off2  = {1'b0, sw_next[10:0] >> sweep_ctl[2:0]};
	assign sw_next2 = sweep_ctl[3] ? ({1'b0, sw_next[10:0]} - sw_off2)
	                               : ({1'b0, sw_next[10:0]} + sw_off2);

	logic [11:0] tr_off, tr_next;
	assign tr_off  = {1'b0, period_set >> sweep_ctl[2:0]};
	assign tr_next = sweep_ctl[3] ? ({1'b0, period_set} - tr_off) : ({1'b0, period_set} + tr_off);

	logic [CNT_W-1:0] rem_try;
	assign rem_try = {rem_q[CNT_W-2:0], dvd_q[DIV_W-1]};

	logic [2:0] pos_new;
	assign pos_new = dpos_q + quo_q[2:0] + 3'd1;

	assign sts.need_div = need_div_now;
	assign sts.div_last = (dcnt_q == 5'd1);

	logic [2:0] pos_sel;
	always_comb begin
		pos_sel = need_div_q ? pos_new : dpos_q;
	end

	// next state for a frame step: length first, then sweep or envelope
	logic        fr_en;
	logic [6:0]  fr_len;
	logic [3:0]  fr_sw_cnt, fr_vol, sw_dec;
	logic [10:0] fr_shadow, fr_period;
	logic [2:0]  fr_env_cnt, env_inc;
	always_comb begin
		fr_en      = enabled_q;
		fr_len     = len_q;
		fr_sw_cnt  = sw_cnt_q;
		fr_shadow  = shadow_q;
		fr_period  = period_q;
		fr_env_cnt = env_cnt_q;
		fr_vol     = vol_q;
		sw_dec     = (sw_cnt_q != 4'd0) ? sw_cnt_q - 4'd1 : 4'd0;
		env_inc    = env_cnt_q + 3'd1;
		if (!step_q[0] && len_en && len_q != 7'd0) begin
			fr_len = len_q - 7'd1;
			if (len_q == 7'd1) fr_en = 1'b0;
		end
		if (fr_en && (step_q == 3'd2 || step_q == 3'd6)) begin
			fr_sw_cnt = sw_dec;
			if (sw_dec == 4'd0) begin
				fr_sw_cnt = (sweep_ctl[6:4] != 3'd0) ? {1'b0, sweep_ctl[6:4]} : 4'd8;
				if (sweep_on_q && sweep_ctl[6:4] != 3'd0) begin
					if (sw_next > 12'd2047) begin
						fr_en = 1'b0;
					end else if (sweep_ctl[2:0] != 3'd0) begin
						fr_shadow = sw_next[10:0];
						fr_period = sw_next[10:0];
						if (sw_next2 > 12'd2047) fr_en = 1'b0;
					end
				end
			end
		end
		if (fr_en && step_q == 3'd7 && env_ctl[2:0] != 3'd0) begin
			if (env_inc >= env_ctl[2:0]) begin
				fr_env_cnt = 3'd0;
				if (env_ctl[3] && vol_q != 4'hF) fr_vol = vol_q + 4'd1;
				else if (!env_ctl[3] && vol_q != 4'd0) fr_vol = vol_q - 4'd1;
			end else begin
				fr_env_cnt = env_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0; sweep_on_q <= 1'b0; period_q <= '0; shadow_q <= '0;
			cnt_q <= '0; dtype_q <= '0; dpos_q <= '0; env_cnt_q <= '0; vol_q <= '0;
			sw_cnt_q <= '0; len_q <= '0; sample_q <= '0; need_div_q <= 1'b0;
			op_q <= '0; cycles_q <= '0; step_q <= '0;
			dvd_q <= '0; quo_q <= '0; rem_q <= '0; dvs_q <= '0; dcnt_q <= '0;
		end else begin
			if (cmd.start) begin
				op_q <= cmd.op; cycles_q <= in_cycles; step_q <= in_step;
				need_div_q <= 1'b0;
			end
			if (cmd.evaluate) begin
				case (op_q)
					OP_TICK: begin
						if (need_div_now) begin
							period_q   <= period_set;
							dvs_q      <= reload_set;
							dvd_q      <= DIV_W'(-cnt_sub);
							rem_q      <= '0;
							quo_q      <= '0;
							dcnt_q     <= 5'(DIV_W);
							need_div_q <= 1'b1;
						end else if (enabled_q && conv_on) begin
							cnt_q <= cnt_sub;
						end
					end
					OP_FRAME: begin
						enabled_q <= fr_en;
						len_q     <= fr_len;
						sw_cnt_q  <= fr_sw_cnt;
						shadow_q  <= fr_shadow;
						period_q  <= fr_period;
						env_cnt_q <= fr_env_cnt;
						vol_q     <= fr_vol;
					end
					OP_TRIGGER: begin
						period_q   <= period_set;
						vol_q      <= env_ctl[7:4];
						dtype_q    <= duty_sel;
						dpos_q     <= 3'd0;
						cnt_q      <= $signed(reload_set);
						if (len_q == 7'd0) len_q <= 7'(LENGTH_FULL);
						env_cnt_q  <= 3'd0;
						shadow_q   <= period_set;
						sw_cnt_q   <= (sweep_ctl[6:4] != 3'd0) ? {1'b0, sweep_ctl[6:4]} : 4'd8;
						sweep_on_q <= (sweep_ctl[6:4] != 3'd0) || (sweep_ctl[2:0] != 3'd0);
						enabled_q  <= conv_on && !((sweep_ctl[2:0] != 3'd0) && tr_next > 12'd2047);
					end
					default: ;
				endcase
			end
			if (cmd.div_step) begin
				if (rem_try >= dvs_q) begin
					rem_q <= rem_try - dvs_q;
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_try;
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
				dvd_q  <= {dvd_q[DIV_W-2:0], 1'b0};
				dcnt_q <= dcnt_q - 5'd1;
			end
			if (cmd.finish) begin
				need_div_q <= 1'b0;
				if (need_div_q) begin
					// remainder r = (-cnt) mod reload; new cnt = reload - r
					cnt_q  <= $signed(dvs_q - rem_q);
					dpos_q <= pos_new;
				end
				if (op_q == OP_TICK) begin
					if (!(enabled_q && conv_on)) sample_q <= 4'd0;
					else sample_q <= patterns[{dtype_q, pos_sel}] ? vol_q : 4'd0;
				end
			end
		end
	end

	assign sample     = sample_q;
	assign chan_on    = enabled_q;
	assign cur_period = period_q;
endmodule
`default_nettype wire

@@ rtl/core/pulse_channel_with_sweep.sv @@
// Top level: square channel with sweep, envelope and length counter.
//
// Channels: s_axis carries one word per item: tdata = {frame_step, cycles},
// tuser = op (0 tick, 1 frame step, 2 trigger). m_axis returns one word per
// item: tdata = {current_period, channel_on, sample}. cfg writes register
// cfg_index with cfg_data; write only while the block is idle.
// Flow: a frame step or trigger passes the evaluate and done states; a tick whose
// timer runs out also steps the bit-serial reload divider. Items go one at a
// time, and the divider sets the worst case.
// Reset clears all channel state; the channel starts disabled and silent.
// When m_axis_tready is low the result holds in its register; one more item
// may be taken, but it waits in the done state until the result leaves.
`default_nettype none
module pulse_channel_with_sweep
	import pcws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // cycles[15:0], frame_step[18:16]
	input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // sample[3:0], channel_on[4], period[15:5]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [6:0]  sweep_ctl_q;
	logic [7:0]  env_ctl_q;
	logic [1:0]  duty_sel_q;
	logic [10:0] period_set_q;
	logic        len_en_q;
	logic [31:0] patterns_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_ctl_q <= '0; env_ctl_q <= '0; duty_sel_q <= '0;
			period_set_q <= '0; len_en_q <= 1'b0; patterns_q <= PATTERNS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SWEEP:    sweep_ctl_q  <= cfg_data[6:0];
				CFG_ENVELOPE: env_ctl_q    <= cfg_data[7:0];
				CFG_DUTY:     duty_sel_q   <= cfg_data[1:0];
				CFG_PERIOD:   period_set_q <= cfg_data[10:0];
				CFG_LENGTH:   len_en_q     <= cfg_data[0];
				CFG_PATTERNS: patterns_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic      busy, in_fire, out_free;
	pcws_cmd_t cmd;
	pcws_sts_t sts;
	logic [3:0]  sample;
	logic        chan_on;
	logic [10:0] cur_period;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	pcws_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_op(s_axis_tuser),
		.sts(sts), .out_free(out_free), .busy(busy), .cmd(cmd)
	);

	pcws_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_cycles(s_axis_tdata[15:0]), .in_step(s_axis_tdata[18:16]),
		.sweep_ctl(sweep_ctl_q), .env_ctl(env_ctl_q), .duty_sel(duty_sel_q),
		.period_set(period_set_q), .len_en(len_en_q), .patterns(patterns_q),
		.sts(sts), .sample(sample), .chan_on(chan_on), .cur_period(cur_period)
	);

	// hold the word until taken; load once the datapath has settled
	logic fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			fin_q         <= 1'b0;
		end else begin
			fin_q <= cmd.finish;
			if (fin_q) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) m_axis_tdata <= {cur_period, chan_on, sample};
	end
endmodule
`default_nettype wire

@@ tb/sv/pcws_checker.sv @@
// Checker: watches the channels of the pulse channel, predicts and compares results.
`timescale 1ns / 1ps
module pcws_checker
	import pcws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [10:0] period;
		logic        on;
		logic [3:0]  level;
	} chan_word_t;

	logic [6:0]  r_sweep;
	logic [7:0]  r_env;
	logic [1:0]  r_duty;
	logic [10:0] r_period;
	logic        r_len_en;
	logic [31:0] r_patterns;

	logic        ch_on, sw_on;
	logic [10:0] ch_period, sw_shadow;
	int          countdown;
	logic [1:0]  duty_kind;
	logic [2:0]  duty_pos;
	logic [3:0]  vol, level;
	logic [2:0]  env_cnt;
	logic [3:0]  sw_cnt;
	logic [6:0]  len_cnt;

	chan_word_t  expected_words[$];

	function automatic bit dac_on();
		return r_env[7:3] != 0;
	endfunction

	function automatic int unsigned reload_len();
		return (PERIOD_BASE - ch_period) * TIMER_SCALE;
	endfunction

	// Next swept period; disable the channel when it runs past eleven bits.
	function automatic int unsigned sweep_calc();
		int unsigned ofs, nxt;
		ofs = sw_shadow >> r_sweep[2:0];
		nxt = r_sweep[3] ? (sw_shadow - ofs) : (sw_shadow + ofs);
		if (nxt > 2047) ch_on = 1'b0;
		return nxt;
	endfunction

	task automatic advance_timer(input int unsigned cyc);
		int unsigned rl, steps;
		if (!(ch_on && dac_on())) begin
			level = 0;
			return;
		end
		countdown -= cyc;
		if (countdown <= 0) begin
			ch_period = r_period;
			rl = reload_len();
			steps = 1 + (-countdown) / rl;
			countdown += steps * rl;
			duty_pos = duty_pos + steps[2:0];
		end
		level = r_patterns[{duty_kind, duty_pos}] ? vol : 4'd0;
	endtask

	task automatic clock_sweep();
		int unsigned pace, nxt;
		pace = r_sweep[6:4];
		if (sw_cnt > 0) sw_cnt--;
		if (sw_cnt != 0) return;
		sw_cnt = pace != 0 ? 4'(pace) : 4'd8;
		if (sw_on && pace != 0) begin
			nxt = sweep_calc();
			if (nxt <= 2047 && r_sweep[2:0] != 0) begin
				sw_shadow = 11'(nxt);
				ch_period = 11'(nxt);
				void'(sweep_calc());
			end
		end
	endtask

	task automatic clock_envelope();
		if (r_env[2:0] == 0) return;
		env_cnt = env_cnt + 3'd1;
		if (env_cnt >= r_env[2:0]) begin
			env_cnt = 0;
			if (r_env[3] && vol < 4'hF) vol++;
			else if (!r_env[3] && vol > 0) vol--;
		end
	endtask

	task automatic frame_step(input logic [2:0] fs);
		if (!fs[0] && r_len_en && len_cnt > 0) begin
			len_cnt--;
			if (len_cnt == 0) ch_on = 1'b0;
		end
		if (!ch_on) return;
		if (fs == 3'd2 || fs == 3'd6) clock_sweep();
		if (fs == 3'd7) clock_envelope();
	endtask

	task automatic trigger_channel();
		ch_on = dac_on();
		ch_period = r_period;
		vol = r_env[7:4];
		duty_kind = r_duty;
		duty_pos = 0;
		countdown = reload_len();
		if (len_cnt == 0) len_cnt = 7'(LENGTH_FULL);
		env_cnt = 0;
		sw_shadow = ch_period;
		sw_cnt = r_sweep[6:4] != 0 ? {1'b0, r_sweep[6:4]} : 4'd8;
		sw_on = r_sweep[6:4] != 0 || r_sweep[2:0] != 0;
		if (r_sweep[2:0] != 0) void'(sweep_calc());
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		chan_word_t w, e;
		if (!arst_n) begin
			r_sweep = 0; r_env = 0; r_duty = 0; r_period = 0; r_len_en = 0;
			r_patterns = PATTERNS_RESET;
			ch_on = 0; sw_on = 0; ch_period = 0; sw_shadow = 0; countdown = 0;
			duty_kind = 0; duty_pos = 0; vol = 0; level = 0; env_cnt = 0;
			sw_cnt = 0; len_cnt = 0;
			expected_words.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SWEEP:    r_sweep = cfg_data[6:0];
					CFG_ENVELOPE: r_env = cfg_data[7:0];
					CFG_DUTY:     r_duty = cfg_data[1:0];
					CFG_PERIOD:   r_period = cfg_data[10:0];
					CFG_LENGTH:   r_len_en = cfg_data[0];
					CFG_PATTERNS: r_patterns = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				w = m_axis_tdata;
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", int'(m_axis_tdata), 0);
				end else begin
					e = expected_words.pop_front();
					if (w.level != e.level) report_mismatch("sample", w.level, e.level);
					if (w.on != e.on) report_mismatch("channel_on", w.on, e.on);
					if (w.period != e.period)
						report_mismatch("current_period", w.period, e.period);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					OP_TICK:    advance_timer(s_axis_tdata[15:0]);
					OP_FRAME:   frame_step(s_axis_tdata[18:16]);
					OP_TRIGGER: trigger_channel();
					default: ;
				endcase
				e.level = level;
				e.on = ch_on;
				e.period = ch_period;
				expected_words.push_back(e);
			end
			pending = expected_words.size();
		end
	end
endmodule

@@ tb/sv/tb.sv @@
// Testbench top: clock, reset, stimulus and verdict for the pulse channel.
`timescale 1ns / 1ps
module tb
	import pcws_pkg::*;
();
	localparam int STALL_LIMIT = 5000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 0;
	logic [1:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int          fail_count, pending;
	int          idle_cycles = 0;
	bit          hold_off = 0;
	bit          sink_random = 1;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	pulse_channel_with_sweep dut (.*);
	pcws_checker chk (.*);

	// Watchdog: count cycles with no word moving anywhere.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("pulse_channel_with_sweep regression: fail");
			$finish;
		end
	end

	// Receiver: random stalls per word, or a long hold when asked.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 0;
			end else if (!sink_random) begin
				m_axis_tready <= 1;
			end else if (m_axis_tready && m_axis_tvalid) begin
				gap = $urandom_range(0, 5);
				if (gap != 0) begin
					m_axis_tready <= 0;
					repeat (gap - 1) @(posedge clk);
					@(posedge clk);
				end
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// Drop valid once the write is taken, then idle before returning.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Valid stays up after acceptance; the next call replaces the item or lowers valid for a gap, and drain() lowers it.
	task automatic send_item(input logic [1:0] op, input logic [15:0] cyc,
			input logic [2:0] fs, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'd0, fs, cyc};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Wait for the pipe to drain, then a little more.
	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending != 0 || s_axis_tvalid) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_item(input bit gaps);
		int k;
		logic [15:0] cyc;
		k = $urandom_range(0, 99);
		cyc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
		if (k < 55) send_item(OP_TICK, cyc, 3'($urandom), gaps);
		else if (k < 88) send_item(OP_FRAME, 16'($urandom), 3'($urandom_range(0, 7)), gaps);
		else if (k < 97) send_item(OP_TRIGGER, 16'($urandom), 3'($urandom), gaps);
		else send_item(OP_UNKNOWN, 16'($urandom), 3'($urandom), gaps);
	endtask

	task automatic random_config(input bit extreme);
		if (extreme) begin
			write_reg(CFG_SWEEP, $urandom_range(0, 1) ? 32'h7F : 32'h00);
			write_reg(CFG_ENVELOPE, $urandom_range(0, 1) ? 32'hFF : 32'hF0);
			write_reg(CFG_PERIOD, $urandom_range(0, 1) ? 32'h7FF : 32'h000);
		end else begin
			write_reg(CFG_SWEEP, $urandom_range(0, 127));
			// mostly keep the converter on so ticks do real work
			write_reg(CFG_ENVELOPE, $urandom_range(0, 7) == 0 ? $urandom_range(0, 7)
				: $urandom_range(8, 255));
			write_reg(CFG_PERIOD, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
				: $urandom_range(1700, 2047));
		end
		write_reg(CFG_DUTY, $urandom_range(0, 3));
		write_reg(CFG_LENGTH, $urandom_range(0, 1));
		write_reg(CFG_PATTERNS, $urandom_range(0, 3) == 0 ? $urandom : PATTERNS_RESET);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset state, unknown op, a tick and a frame step with converter off.
		send_item(OP_UNKNOWN, 16'hFFFF, 3'd7, 1'b0);
		send_item(OP_TICK, 16'hFFFF, 3'd0, 1'b0);
		send_item(OP_FRAME, 16'd0, 3'd2, 1'b0);
		drain();
		write_reg(CFG_SWEEP, 32'h11);
		write_reg(CFG_ENVELOPE, 32'hF1);
		write_reg(CFG_DUTY, 32'd3);
		write_reg(CFG_PERIOD, 32'h7FF);
		write_reg(CFG_LENGTH, 32'd1);
		write_reg(CFG_PATTERNS, 32'hFFFF_FFFF);
		send_item(OP_TRIGGER, 16'd0, 3'd0, 1'b0);
		send_item(OP_TICK, 16'd0, 3'd0, 1'b0);
		send_item(OP_TICK, 16'hFFFF, 3'd0, 1'b0);
		send_item(OP_TICK, 16'd3, 3'd0, 1'b0);
		for (int s = 0; s < 8; s++) send_item(OP_FRAME, 16'd0, s[2:0], 1'b0);
		drain();
		// Overflowing upward sweep, then zero paces.
		write_reg(CFG_SWEEP, 32'h71);
		write_reg(CFG_PERIOD, 32'h600);
		write_reg(CFG_ENVELOPE, 32'h08);
		send_item(OP_TRIGGER, 16'd0, 3'd0, 1'b0);
		send_item(OP_FRAME, 16'd0, 3'd2, 1'b0);
		send_item(OP_FRAME, 16'd0, 3'd7, 1'b0);
		send_item(OP_TICK, 16'd100, 3'd0, 1'b0);
		drain();
		write_reg(CFG_SWEEP, 32'h0F);
		write_reg(CFG_PERIOD, 32'h000);
		write_reg(CFG_ENVELOPE, 32'h90);
		send_item(OP_TRIGGER, 16'd0, 3'd0, 1'b0);
		send_item(OP_FRAME, 16'd0, 3'd6, 1'b0);
		send_item(OP_FRAME, 16'd0, 3'd7, 1'b0);
		send_item(OP_TICK, 16'd9000, 3'd0, 1'b0);
		drain();

		// Random phases, extremes among the settings.
		for (int ph = 0; ph < 12; ph++) begin
			random_config(ph % 4 == 1);
			send_item(OP_TRIGGER, 16'd0, 3'd0, 1'b1);
			for (int i = 0; i < 48; i++) random_item(ph % 3 != 2);
			drain();
		end

		// Hold the receiver off while items keep coming so the input stalls.
		hold_off = 1;
		fork
			begin
				int held;
				held = 0;
				while (held < 300) begin
					@(posedge clk);
					held++;
				end
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++) random_item(1'b0);
		join
		drain();

		if (fail_count == 0)
			$display("pulse_channel_with_sweep regression: pass");
		else
			$display("pulse_channel_with_sweep regression: fail");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/pcws_pkg.sv
rtl/core/pcws_ctrl.sv
rtl/core/pcws_dp.sv
rtl/core/pulse_channel_with_sweep.sv
tb/sv/pcws_checker.sv
tb/sv/tb.sv
